// File: hw/rtl/i2bd_pkg.sv
// ----------------------------------------------------------------------------
// i2bd_pkg: shared types and constants for the base-digit converter
// Field widths, digit store sizing, queue sizing and the glyph mapping.
// ----------------------------------------------------------------------------
package i2bd_pkg;

  // Field widths
  localparam int VALUE_W = 63;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Digit store sizing
  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // Divider: a 64-bit dividend walked a byte per cycle
  localparam int WORK_W      = 64;
  localparam int CHUNK_W     = 8;
  localparam int NCHUNK      = WORK_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(NCHUNK);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  // ASCII anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DEC_TOP  = DIGIT_W'(10);

  // One queued conversion job
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               is_zero;
  } job_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_TOP) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_TOP);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/i2bd_ram.sv
// ----------------------------------------------------------------------------
// i2bd_ram: generic single-write, single-read RAM
// Registered read; read data holds while no read is issued.
// ----------------------------------------------------------------------------
module i2bd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/i2bd_front.sv
// ----------------------------------------------------------------------------
// i2bd_front: input side of the converter
// Holds the radix register, accepts words, flags zero inputs and queues jobs.
// ----------------------------------------------------------------------------
module i2bd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2bd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2bd_pkg::VALUE_W-1:0]  in_value,
  output logic                          job_valid,
  input  logic                          job_ready,
  output i2bd_pkg::job_t                job
);
  import i2bd_pkg::*;

  logic [RADIX_W-1:0] radix_r, radix_nxt;
  job_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  q_cnt_r, q_cnt_nxt;
  logic               push, pop;
  job_t               new_job;

  // Keep radix unless the write lands in the legal range
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we && cfg_data >= RADIX_MIN && cfg_data <= RADIX_MAX) begin
      radix_nxt = cfg_data;
    end
  end

  // Classify the incoming word
  always_comb begin
    new_job.value   = in_value;
    new_job.radix   = radix_r;
    new_job.is_zero = (in_value == '0);
  end

  assign in_ready  = (q_cnt_r != QCNT_W'(QDEPTH));
  assign job_valid = (q_cnt_r != '0);
  assign job       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // Advance queue pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      radix_r  <= radix_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

// File: hw/rtl/i2bd_back.sv
// ----------------------------------------------------------------------------
// i2bd_back: divide and emit engine
// Divides a byte per cycle to peel off digits, stores them, then streams them
// out most significant first through an output register.
// ----------------------------------------------------------------------------
module i2bd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  i2bd_pkg::job_t               job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [i2bd_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                         out_last_digit
);
  import i2bd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WORK_W-1:0]      work_r, work_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic [CHUNK_CNT_W-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       emit_left_r, emit_left_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   pend_last_r, pend_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [CHUNK_W-1:0]     qbyte;
  logic [DIGIT_W-1:0]     step_rem;
  logic [WORK_W-1:0]      step_work;

  logic                   accept, load, issue;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0]     ram_wdata, ram_rdata;
  logic [CNT_W-1:0]       rd_pos;

  // One byte of restoring division by the current base
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W:0]   diff;
    logic [CHUNK_W-1:0] top;
    r     = rem_r;
    qbyte = '0;
    top   = work_r[WORK_W-1 -: CHUNK_W];
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      t    = {r, top[i]};
      diff = t - base_r;
      if (t >= base_r) begin
        r        = diff[DIGIT_W-1:0];
        qbyte[i] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    step_rem  = r;
    step_work = {work_r[WORK_W-CHUNK_W-1:0], qbyte};
  end

  // Job and output side handshakes
  assign accept    = (state_r == S_IDLE) && job_valid;
  assign job_ready = (state_r == S_IDLE);
  assign load      = rd_pend_r && (!out_valid_r || out_ready);
  assign issue     = (state_r == S_EMIT) && (emit_left_r != '0) && (!rd_pend_r || load);
  assign rd_pos    = emit_left_r - 1'b1;
  assign ram_raddr = rd_pos[ADDR_W-1:0];

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    emit_left_nxt = emit_left_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = step_rem;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          base_nxt  = job.radix;
          work_nxt  = WORK_W'(job.value);
          rem_nxt   = '0;
          chunk_nxt = '0;
          cnt_nxt   = '0;
          if (job.is_zero) begin
            // zero converts straight to a single '0' digit
            ram_we        = 1'b1;
            ram_waddr     = '0;
            ram_wdata     = '0;
            cnt_nxt       = CNT_W'(1);
            emit_left_nxt = CNT_W'(1);
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        work_nxt  = step_work;
        rem_nxt   = step_rem;
        chunk_nxt = chunk_r + 1'b1;
        if (chunk_r == CHUNK_CNT_W'(NCHUNK - 1)) begin
          // digit done: store it unless the store is full
          rem_nxt = '0;
          if (cnt_r < CNT_W'(MAX_DIGITS)) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (step_work == '0) begin
            emit_left_nxt = (cnt_r < CNT_W'(MAX_DIGITS)) ? cnt_r + 1'b1 : cnt_r;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (issue) begin
          emit_left_nxt = emit_left_r - 1'b1;
        end
        if (emit_left_r == '0 && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Read pipeline and output register
  always_comb begin
    rd_pend_nxt   = issue || (rd_pend_r && !load);
    pend_last_nxt = issue ? (emit_left_r == CNT_W'(1)) : pend_last_r;
    out_valid_nxt = load || (out_valid_r && !out_ready);
    out_char_nxt  = load ? glyph(ram_rdata) : out_char_r;
    out_last_nxt  = load ? pend_last_r : out_last_r;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      cnt_r       <= '0;
      emit_left_r <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      cnt_r       <= cnt_nxt;
      emit_left_r <= emit_left_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    pend_last_r <= pend_last_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // Digit store
  i2bd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTH
  // Base stays legal while dividing
  a_base_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (base_r >= RADIX_MIN && base_r <= RADIX_MAX))
    else $error("divider base out of range");

  // Partial remainder stays below the base
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> ({1'b0, rem_r} < base_r))
    else $error("remainder not below base");

  // No read is left in flight when a new job can start
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rd_pend_r)
    else $error("read pending in idle");

  // A fetched digit that cannot load is held for the next cycle
  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r && out_valid_r && !out_ready |=> rd_pend_r && $stable(ram_rdata))
    else $error("pending digit lost");

  // The final digit of a run closes the emit phase
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    load && pend_last_r |-> emit_left_r == '0)
    else $error("last digit loaded with digits left");
`endif

endmodule

// File: hw/rtl/integer_to_base_digits_core.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_core: integer to ASCII digits in base 2..16
// Flow: the divider does a byte per cycle to peel off each digit, then the digits
//   stream out most significant first; a zero word skips the divider.
// Queueing: a two-entry job queue takes new words while a conversion runs.
// Reset: synchronous active-low rst_n clears control state, radix returns to 10.
// ----------------------------------------------------------------------------
module integer_to_base_digits_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2bd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2bd_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2bd_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last_digit
);
  import i2bd_pkg::*;

  job_t job;
  logic job_valid;
  logic job_ready;

  // Accept and queue words
  i2bd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job)
  );

  // Convert and stream digits
  i2bd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

endmodule
